// ----- hw/rtl/mac_allow_list_table_top_macros.svh -----
// Assertion macros used by the allow-list table sequencer.
`ifndef MAC_ALLOW_LIST_TABLE_TOP_MACROS_SVH
`define MAC_ALLOW_LIST_TABLE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define MAL_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);
`define MAL_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) else $error(msg);
`else
`define MAL_ASSERT(lbl, clk, rstn, prop, msg)
`define MAL_NEVER(lbl, clk, rstn, expr, msg)
`endif
`endif

// ----- hw/rtl/mal_pkg.sv -----
// Types and constants of the MAC allow-list table.
package mal_pkg;

    localparam int OP_W      = 3;
    localparam int ST_W      = 3;
    localparam int MAC_W     = 48;
    localparam int IDX_OUT_W = 5;
    localparam int CNT_OUT_W = 6;
    localparam int MAX_LIST  = 32;
    localparam int OUT_TDATA_W = 64;
    localparam int OUT_PAD_W = OUT_TDATA_W - (IDX_OUT_W + 1 + MAC_W + CNT_OUT_W);

    typedef enum logic [OP_W-1:0] {
        OP_NOP    = 3'd0,
        OP_ADD    = 3'd1,
        OP_DEL    = 3'd2,
        OP_LOOKUP = 3'd3,
        OP_LIST   = 3'd4
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 3'd0,
        ST_DUP   = 3'd1,
        ST_FULL  = 3'd2,
        ST_MISS  = 3'd3,
        ST_BADOP = 3'd4
    } status_t;

    typedef struct packed {
        logic [ST_W-1:0]      status;
        logic [IDX_OUT_W-1:0] index;
        logic                 accepted;
        logic [MAC_W-1:0]     mac;
        logic [CNT_OUT_W-1:0] count;
        logic                 last;
    } mal_res_t;

endpackage

// ----- hw/rtl/mac_allow_list_table_top.sv -----
// Top level of the MAC allow-list table: stream ports, sequencer and output register.
//
// Each transfer on the input stream carries one command; the block takes it when s_tready is
// high and then works on it alone until its last result has been moved into the output
// register. Nop, bad opcodes and commands on an empty table go straight to the response. Add,
// delete and lookup search the table one entry per cycle through the RAM read port and a
// single 48-bit comparator; a delete that hits an entry then compacts the table behind it
// through the one RAM write port. List gives one result per cycle while the output is not
// stalled, up to 32, with m_tlast on the final one. The table needs no clearing pass after
// reset, since only entries below the entry count are ever used.
module mac_allow_list_table_top
    import mal_pkg::*;
#(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [MAC_W-1:0]       s_tdata,  // [47:0] mac_address
    input  logic [OP_W-1:0]        s_tuser,  // [2:0] opcode
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [4:0] match_index, [5] accepted, [53:6] entry_mac, [59:54] entry_count, [63:60] zero
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic [ST_W-1:0]        m_tuser,  // [2:0] status
    output logic                   m_tlast
);

    mal_res_t res;
    logic     res_valid;
    logic     out_free;
    mal_res_t out_reg;
    logic     m_tvalid_reg;

    mal_seq #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_op    (s_tuser),
        .in_mac   (s_tdata),
        .res_valid(res_valid),
        .res_ready(out_free),
        .res      (res)
    );

    // The output register takes a new result whenever its current one is gone or leaving.
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_free) begin
            m_tvalid_reg <= res_valid;
        end
        if (out_free && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_reg.count, out_reg.mac, out_reg.accepted,
                       out_reg.index};
    assign m_tuser  = out_reg.status;
    assign m_tlast  = out_reg.last;

endmodule

// ----- hw/rtl/mal_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module mal_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/mal_seq.sv -----
// Sequencer of the allow-list table: search, append, compaction and listing over one RAM.
`include "mac_allow_list_table_top_macros.svh"
module mal_seq
    import mal_pkg::*;
#(
    parameter int TABLE_DEPTH = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [OP_W-1:0]  in_op,
    input  logic [MAC_W-1:0] in_mac,
    output logic             res_valid,
    input  logic             res_ready,
    output mal_res_t         res
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int SW    = CNT_W + 7;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_SHIFT = 5'b00100,
        S_LIST  = 5'b01000,
        S_RESP  = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    logic [OP_W-1:0]      op_reg, op_next;
    logic [MAC_W-1:0]     mac_reg, mac_next;
    logic [IDX_W-1:0]     scan_idx_reg, scan_idx_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [ST_W-1:0]      st_reg, st_next;
    logic [IDX_OUT_W-1:0] res_idx_reg, res_idx_next;
    logic                 acc_reg, acc_next;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [MAC_W-1:0] mem_wdata;
    logic [IDX_W-1:0] mem_raddr;
    logic [MAC_W-1:0] rd_data;

    logic [SW-1:0] idx_ext, cnt_ext, list_n;
    logic          match, is_end, is_full, shift_more, list_last;

    mal_ram #(
        .WIDTH(MAC_W),
        .DEPTH(TABLE_DEPTH)
    ) u_ram (
        .aclk (aclk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .raddr(mem_raddr),
        .rdata(rd_data)
    );

    assign idx_ext    = SW'(scan_idx_reg);
    assign cnt_ext    = SW'(count_reg);
    assign list_n     = (cnt_ext > SW'(MAX_LIST)) ? SW'(MAX_LIST) : cnt_ext;
    // The single 48-bit comparator, applied to one stored entry per cycle.
    assign match      = (rd_data == mac_reg);
    assign is_end     = (idx_ext + SW'(1)) == cnt_ext;
    assign is_full    = cnt_ext == SW'(TABLE_DEPTH);
    assign shift_more = (idx_ext + SW'(2)) < cnt_ext;
    assign list_last  = (idx_ext + SW'(1)) == list_n;

    assign in_ready = (state_reg == S_IDLE);

    always_comb begin
        res_valid = 1'b0;
        res.status   = st_reg;
        res.index    = res_idx_reg;
        res.accepted = acc_reg;
        res.mac      = '0;
        res.count    = cnt_ext[CNT_OUT_W-1:0];
        res.last     = 1'b1;
        case (state_reg)
            S_LIST: begin
                res_valid    = 1'b1;
                res.status   = ST_OK;
                res.index    = idx_ext[IDX_OUT_W-1:0];
                res.accepted = 1'b0;
                res.mac      = rd_data;
                res.last     = list_last;
            end
            S_RESP: begin
                res_valid = 1'b1;
            end
            default: begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        mac_next      = mac_reg;
        scan_idx_next = scan_idx_reg;
        count_next    = count_reg;
        st_next       = st_reg;
        res_idx_next  = res_idx_reg;
        acc_next      = acc_reg;
        mem_we        = 1'b0;
        mem_waddr     = scan_idx_reg;
        mem_wdata     = rd_data;
        mem_raddr     = '0;
        case (state_reg)
            S_IDLE: begin
                // Entry 0 is read here so that its data is ready in the first scan cycle.
                if (in_valid) begin
                    op_next       = in_op;
                    mac_next      = in_mac;
                    scan_idx_next = '0;
                    st_next       = ST_OK;
                    res_idx_next  = '0;
                    acc_next      = 1'b0;
                    state_next    = S_RESP;
                    case (in_op)
                        OP_NOP: begin
                            st_next = ST_OK;
                        end
                        OP_ADD: begin
                            if (count_reg == '0) begin
                                mem_we     = 1'b1;
                                mem_waddr  = '0;
                                mem_wdata  = in_mac;
                                count_next = CNT_W'(1);
                            end else begin
                                state_next = S_SCAN;
                            end
                        end
                        OP_DEL: begin
                            if (count_reg == '0) begin
                                st_next = ST_MISS;
                            end else begin
                                state_next = S_SCAN;
                            end
                        end
                        OP_LOOKUP: begin
                            if (count_reg == '0) begin
                                acc_next = 1'b1;
                            end else begin
                                state_next = S_SCAN;
                            end
                        end
                        OP_LIST: begin
                            if (count_reg == '0) begin
                                st_next = ST_MISS;
                            end else begin
                                state_next = S_LIST;
                            end
                        end
                        default: begin
                            st_next = ST_BADOP;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                mem_raddr = IDX_W'(idx_ext + SW'(1));
                if (match) begin
                    res_idx_next = idx_ext[IDX_OUT_W-1:0];
                    state_next   = S_RESP;
                    case (op_reg)
                        OP_ADD: begin
                            st_next = ST_DUP;
                        end
                        OP_DEL: begin
                            st_next = ST_OK;
                            // The entry behind the hit is already being read for the shift.
                            if (is_end) begin
                                count_next = count_reg - CNT_W'(1);
                            end else begin
                                state_next = S_SHIFT;
                            end
                        end
                        default: begin
                            st_next  = ST_OK;
                            acc_next = 1'b1;
                        end
                    endcase
                end else if (is_end) begin
                    state_next = S_RESP;
                    case (op_reg)
                        OP_ADD: begin
                            if (is_full) begin
                                st_next = ST_FULL;
                            end else begin
                                mem_we       = 1'b1;
                                mem_waddr    = cnt_ext[IDX_W-1:0];
                                mem_wdata    = mac_reg;
                                count_next   = count_reg + CNT_W'(1);
                                st_next      = ST_OK;
                                res_idx_next = cnt_ext[IDX_OUT_W-1:0];
                            end
                        end
                        default: begin
                            st_next = ST_MISS;
                        end
                    endcase
                end else begin
                    scan_idx_next = IDX_W'(idx_ext + SW'(1));
                end
            end
            S_SHIFT: begin
                // Move entry scan_idx+1 down one place while entry scan_idx+2 is read.
                mem_we    = 1'b1;
                mem_waddr = scan_idx_reg;
                mem_wdata = rd_data;
                mem_raddr = IDX_W'(idx_ext + SW'(2));
                if (shift_more) begin
                    scan_idx_next = IDX_W'(idx_ext + SW'(1));
                end else begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_RESP;
                end
            end
            S_LIST: begin
                // Hold the read address while the result is stalled.
                if (res_ready) begin
                    mem_raddr = IDX_W'(idx_ext + SW'(1));
                    if (list_last) begin
                        state_next = S_IDLE;
                    end else begin
                        scan_idx_next = IDX_W'(idx_ext + SW'(1));
                    end
                end else begin
                    mem_raddr = scan_idx_reg;
                end
            end
            S_RESP: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
        op_reg       <= op_next;
        mac_reg      <= mac_next;
        scan_idx_reg <= scan_idx_next;
        st_reg       <= st_next;
        res_idx_reg  <= res_idx_next;
        acc_reg      <= acc_next;
    end

    `MAL_NEVER(a_count_max, aclk, aresetn, cnt_ext > SW'(TABLE_DEPTH), "entry count above depth")
    `MAL_ASSERT(a_count_hold, aclk, aresetn, (state_reg == S_LIST || state_reg == S_RESP) |=> $stable(count_reg), "entry count moved while reporting")
    `MAL_ASSERT(a_shift_del, aclk, aresetn, (state_reg == S_SHIFT) |-> (op_reg == OP_DEL && (idx_ext + SW'(1)) < cnt_ext), "compaction outside a delete")
    `MAL_ASSERT(a_scan_range, aclk, aresetn, (state_reg == S_SCAN || state_reg == S_LIST) |-> (idx_ext < cnt_ext), "scan index beyond valid entries")

endmodule
